// File: hw/rtl/epg_pkg.sv
package epg_pkg;

  localparam int K_W       = 10;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 17;
  localparam int PT_W      = 16;
  localparam int AX_W      = 17;

  localparam int MUL_W  = 34;
  localparam int PROD_W = 2 * MUL_W;
  localparam int DVD_W  = 52;
  localparam int DVS_W  = 36;
  localparam int QUO_W  = 32;
  localparam int SQ_W   = 63;
  localparam int ROOT_W = 32;

  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  localparam logic [3:0] SIN_LAST = 4'd4;
  localparam logic [3:0] COS_LAST = 4'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_AXIS_X   = 2'd2,
    REG_AXIS_Y   = 2'd3
  } reg_idx_t;

  typedef enum logic [4:0] {
    OP_NONE  = 5'd0,
    OP_LOAD  = 5'd1,
    OP_ANGLE = 5'd2,
    OP_ADIV  = 5'd3,
    OP_THETA = 5'd4,
    OP_X2    = 5'd5,
    OP_HP    = 5'd6,
    OP_HQ    = 5'd7,
    OP_HC    = 5'd8,
    OP_SMUL  = 5'd9,
    OP_SIN   = 5'd10,
    OP_COS   = 5'd11,
    OP_U     = 5'd12,
    OP_V     = 5'd13,
    OP_SQ1   = 5'd14,
    OP_SQ2   = 5'd15,
    OP_SQ3   = 5'd16,
    OP_ROOT  = 5'd17,
    OP_DEN   = 5'd18,
    OP_DXS   = 5'd19,
    OP_DX    = 5'd20,
    OP_DYS   = 5'd21,
    OP_DY    = 5'd22,
    OP_EMIT  = 5'd23,
    OP_AQ    = 5'd24,
    OP_TSQ   = 5'd25
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic is_close;
    logic is_beyond;
    logic zero_axis;
    logic den_zero;
    logic dup;
  } dp_stat_t;

  // floor(2^34 / d) for the Horner divisors
  function automatic logic [MUL_W-1:0] horner_recip(input logic [3:0] i);
    logic [MUL_W-1:0] m;
    case (i)
      4'd0:    m = 34'd156180628;
      4'd1:    m = 34'd238609294;
      4'd2:    m = 34'd409044504;
      4'd3:    m = 34'd858993459;
      4'd4:    m = 34'd2863311530;
      4'd5:    m = 34'd130150524;
      4'd6:    m = 34'd190887435;
      4'd7:    m = 34'd306783378;
      4'd8:    m = 34'd572662306;
      4'd9:    m = 34'd1431655765;
      4'd10:   m = 34'd8589934592;
      default: m = '0;
    endcase
    return m;
  endfunction

  function automatic logic [7:0] horner_div(input logic [3:0] i);
    logic [7:0] d;
    case (i)
      4'd0:    d = 8'd110;
      4'd1:    d = 8'd72;
      4'd2:    d = 8'd42;
      4'd3:    d = 8'd20;
      4'd4:    d = 8'd6;
      4'd5:    d = 8'd132;
      4'd6:    d = 8'd90;
      4'd7:    d = 8'd56;
      4'd8:    d = 8'd30;
      4'd9:    d = 8'd12;
      4'd10:   d = 8'd2;
      default: d = 8'd1;
    endcase
    return d;
  endfunction

endpackage

// File: hw/rtl/epg_if.sv
interface epg_in_if;
  logic                      valid;
  logic                      ready;
  logic [epg_pkg::K_W-1:0]   step_index;
  modport source(output valid, output step_index, input ready);
  modport sink(input valid, input step_index, output ready);
endinterface

interface epg_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [epg_pkg::PT_W-1:0]  point_x;
  logic signed [epg_pkg::PT_W-1:0]  point_y;
  logic                             closing;
  modport source(output valid, output point_x, output point_y, output closing, input ready);
  modport sink(input valid, input point_x, input point_y, input closing, output ready);
endinterface

interface epg_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [epg_pkg::CFG_IDX_W-1:0]   index;
  logic [epg_pkg::CFG_DAT_W-1:0]   data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/epg_div.sv
module epg_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [epg_pkg::DVD_W-1:0]   dividend,
  input  logic [epg_pkg::DVS_W-1:0]   divisor,
  output logic                        done,
  output logic [epg_pkg::QUO_W-1:0]   quotient
);

  localparam int CNT_W = $clog2(epg_pkg::QUO_W);
  localparam int REM_W = epg_pkg::DVS_W + 1;

  logic [REM_W-1:0]          rem_r, rem_nxt;
  logic [epg_pkg::QUO_W-1:0] quo_r, quo_nxt;
  logic [epg_pkg::DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      busy_r, done_r;
  logic [REM_W-1:0]          trial;
  logic                      ge;

  always_comb begin
    trial   = {rem_r[REM_W-2:0], quo_r[epg_pkg::QUO_W-1]};
    ge      = trial >= {1'b0, dvs_r};
    rem_nxt = ge ? (trial - {1'b0, dvs_r}) : trial;
    quo_nxt = {quo_r[epg_pkg::QUO_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == {CNT_W{1'b1}}) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= REM_W'(dividend[epg_pkg::DVD_W-1:epg_pkg::QUO_W]);
      quo_r <= dividend[epg_pkg::QUO_W-1:0];
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: hw/rtl/epg_sqrt.sv
module epg_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [epg_pkg::SQ_W-1:0]     radicand,
  output logic                         done,
  output logic [epg_pkg::ROOT_W-1:0]   root
);

  logic [epg_pkg::SQ_W-1:0] n_r, res_r, bit_r, sum;
  logic                     busy_r, done_r;

  assign sum = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r[0]) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= radicand;
      res_r <= '0;
      bit_r <= {1'b1, {(epg_pkg::SQ_W-1){1'b0}}};
    end else if (busy_r) begin
      if (n_r >= sum) begin
        n_r   <= n_r - sum;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = res_r[epg_pkg::ROOT_W-1:0];

endmodule

// File: hw/rtl/epg_dp.sv
module epg_dp #(
  parameter int SEGMENTS = 600
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [epg_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [epg_pkg::CFG_DAT_W-1:0]       cfg_data,
  input  logic [epg_pkg::K_W-1:0]             in_k,
  input  epg_pkg::dp_cmd_t                    cmd,
  output epg_pkg::dp_stat_t                   stat,
  output logic signed [epg_pkg::PT_W-1:0]     point_x,
  output logic signed [epg_pkg::PT_W-1:0]     point_y,
  output logic                                closing
);

  localparam logic [10:0] SEG_K  = 11'(SEGMENTS);
  localparam logic [12:0] SEG_1  = 13'(SEGMENTS);
  localparam logic [12:0] SEG_2  = 13'(2 * SEGMENTS);
  localparam logic [12:0] SEG_3  = 13'(3 * SEGMENTS);
  localparam logic [20:0] HALF_S = 21'(SEGMENTS / 2);
  localparam logic [21:0] SEG_A  = 22'(SEGMENTS);

  // theta = r*ANG_QUO + (r*ANG_REM + SEGMENTS/2) / SEGMENTS
  localparam logic [30:0] ANG_QUO   = 31'(epg_pkg::HALF_PI_Q30 / SEGMENTS);
  localparam logic [10:0] ANG_REM   = 11'(epg_pkg::HALF_PI_Q30 % SEGMENTS);
  localparam logic [33:0] ANG_RECIP = 34'(64'h4_0000_0000 / 64'(SEGMENTS));

  function automatic logic [17:0] to_q17(input logic [31:0] v);
    logic [31:0] vc;
    vc = (v > 32'(epg_pkg::Q30_ONE)) ? 32'(epg_pkg::Q30_ONE) : v;
    return 18'((vc + 32'd4096) >> 13);
  endfunction

  logic signed [15:0] center_x_r, center_y_r;
  logic signed [16:0] axis_x_r, axis_y_r;
  logic signed [15:0] last_x_r, last_y_r, first_x_r, first_y_r;
  logic               have_first_r;
  logic [epg_pkg::K_W-1:0] k_r;
  logic [1:0]         q_r;
  logic [20:0]        ax_r;
  logic [17:0]        aq_r;
  logic [30:0]        theta_r, t_r;
  logic [31:0]        x2_r;
  logic [32:0]        p_r;
  logic [17:0]        c_r, s_r;
  logic [33:0]        u_r, v_r;
  logic [61:0]        usq_r;
  logic [34:0]        den_r;
  logic signed [18:0] dx_r, dy_r;
  logic [epg_pkg::PROD_W-1:0] prod_r;
  logic signed [15:0] pt_x_r, pt_y_r;
  logic               closing_r;

  logic [epg_pkg::MUL_W-1:0] mul_a, mul_b;
  logic [12:0] k4, r_full;
  logic [1:0]  q_c;
  logic [20:0] ang_x;
  logic [17:0] aq0, aq_c;
  logic [21:0] arem;
  logic [16:0] ma, mb;
  logic [17:0] mc, ms;
  logic        neg_c, neg_s, nab;
  logic [33:0] uv_or;
  logic [1:0]  sh;
  logic [30:0] us, vs;
  logic [32:0] q0;
  logic [40:0] qd;
  logic [33:0] hrem, qdiv;
  logic [30:0] t_hc;
  logic [17:0] mag;
  logic signed [19:0] sx, sy;
  logic signed [15:0] px, py;

  logic                        div_start, div_done, sqrt_done;
  logic [epg_pkg::DVD_W-1:0]   div_dvd;
  logic [epg_pkg::DVS_W-1:0]   div_dvs;
  logic [epg_pkg::QUO_W-1:0]   div_quo;
  logic [epg_pkg::ROOT_W-1:0]  root;

  always_comb begin
    k4     = {1'b0, k_r, 2'b00};
    if (k4 >= SEG_3) begin
      q_c = 2'd3; r_full = k4 - SEG_3;
    end else if (k4 >= SEG_2) begin
      q_c = 2'd2; r_full = k4 - SEG_2;
    end else if (k4 >= SEG_1) begin
      q_c = 2'd1; r_full = k4 - SEG_1;
    end else begin
      q_c = 2'd0; r_full = k4;
    end

    ang_x = 21'(prod_r[19:0]) + HALF_S;
    aq0   = prod_r[51:34];
    arem  = {1'b0, ax_r} - (22'(aq0) * SEG_A);
    aq_c  = aq0 + 18'(arem >= SEG_A);

    ma    = axis_x_r[16] ? 17'(-axis_x_r) : 17'(axis_x_r);
    mb    = axis_y_r[16] ? 17'(-axis_y_r) : 17'(axis_y_r);
    mc    = q_r[0] ? s_r : c_r;
    ms    = q_r[0] ? c_r : s_r;
    neg_c = q_r[0] ^ q_r[1];
    neg_s = q_r[1];
    nab   = axis_x_r[16] ^ axis_y_r[16];

    uv_or = u_r | v_r;
    if (uv_or[33])      sh = 2'd3;
    else if (uv_or[32]) sh = 2'd2;
    else if (uv_or[31]) sh = 2'd1;
    else                sh = 2'd0;
    us = 31'(u_r >> sh);
    vs = 31'(v_r >> sh);

    q0   = prod_r[66:34];
    qd   = q0 * epg_pkg::horner_div(cmd.idx);
    hrem = {1'b0, p_r} - qd[33:0];
    qdiv = {1'b0, q0} + 34'(hrem >= 34'(epg_pkg::horner_div(cmd.idx)));
    t_hc = (qdiv >= 34'(epg_pkg::Q30_ONE)) ? '0 : (epg_pkg::Q30_ONE - qdiv[30:0]);

    mag = div_quo[17:0];

    sx = 20'(center_x_r) + 20'(dx_r);
    sy = 20'(center_y_r) + 20'(dy_r);
    if (sx > 20'sd32767)       px = 16'sh7fff;
    else if (sx < -20'sd32768) px = 16'sh8000;
    else                       px = sx[15:0];
    if (sy > 20'sd32767)       py = 16'sh7fff;
    else if (sy < -20'sd32768) py = 16'sh8000;
    else                       py = sy[15:0];
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      epg_pkg::OP_ANGLE: begin
        mul_a = 34'(r_full);
        mul_b = 34'(ANG_REM);
      end
      epg_pkg::OP_ADIV: begin
        mul_a = 34'(ang_x);
        mul_b = ANG_RECIP;
      end
      epg_pkg::OP_AQ: begin
        mul_a = 34'(r_full);
        mul_b = 34'(ANG_QUO);
      end
      epg_pkg::OP_TSQ: begin
        mul_a = 34'(theta_r);
        mul_b = 34'(theta_r);
      end
      epg_pkg::OP_HP: begin
        mul_a = 34'(x2_r);
        mul_b = 34'(t_r);
      end
      epg_pkg::OP_HQ: begin
        mul_a = 34'(prod_r[62:30]);
        mul_b = epg_pkg::horner_recip(cmd.idx);
      end
      epg_pkg::OP_SMUL: begin
        mul_a = 34'(theta_r);
        mul_b = 34'(t_r);
      end
      epg_pkg::OP_U: begin
        mul_a = 34'(mb);
        mul_b = 34'(mc);
      end
      epg_pkg::OP_V: begin
        mul_a = 34'(ma);
        mul_b = 34'(ms);
      end
      epg_pkg::OP_SQ2: begin
        mul_a = 34'(us);
        mul_b = 34'(us);
      end
      epg_pkg::OP_SQ3: begin
        mul_a = 34'(vs);
        mul_b = 34'(vs);
      end
      epg_pkg::OP_DEN: begin
        mul_a = 34'(ma);
        mul_b = u_r;
      end
      epg_pkg::OP_DX: begin
        mul_a = 34'(mb);
        mul_b = v_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    case (cmd.op)
      epg_pkg::OP_DXS, epg_pkg::OP_DYS: begin
        div_start = 1'b1;
        div_dvd   = {prod_r[50:0], 1'b0} + epg_pkg::DVD_W'(den_r);
        div_dvs   = {den_r, 1'b0};
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  epg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  epg_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.op == epg_pkg::OP_ROOT),
    .radicand (63'(usq_r) + 63'(prod_r[61:0])),
    .done     (sqrt_done),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r   <= '0;
      center_y_r   <= '0;
      axis_x_r     <= '0;
      axis_y_r     <= '0;
      last_x_r     <= '0;
      last_y_r     <= '0;
      first_x_r    <= '0;
      first_y_r    <= '0;
      have_first_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (epg_pkg::reg_idx_t'(cfg_idx))
          epg_pkg::REG_CENTER_X: center_x_r <= cfg_data[15:0];
          epg_pkg::REG_CENTER_Y: center_y_r <= cfg_data[15:0];
          epg_pkg::REG_AXIS_X:   axis_x_r   <= cfg_data;
          epg_pkg::REG_AXIS_Y:   axis_y_r   <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.op == epg_pkg::OP_EMIT) begin
        if (stat.is_close) begin
          have_first_r <= 1'b0;
        end else begin
          if (k_r == '0 || !have_first_r) begin
            first_x_r    <= px;
            first_y_r    <= py;
            have_first_r <= 1'b1;
          end
          last_x_r <= px;
          last_y_r <= py;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (cmd.op)
      epg_pkg::OP_LOAD: begin
        k_r  <= in_k;
        dx_r <= '0;
        dy_r <= '0;
      end
      epg_pkg::OP_ANGLE: q_r <= q_c;
      epg_pkg::OP_ADIV:  ax_r <= ang_x;
      epg_pkg::OP_AQ:    aq_r <= aq_c;
      epg_pkg::OP_THETA: theta_r <= prod_r[30:0] + 31'(aq_r);
      epg_pkg::OP_X2: begin
        x2_r <= prod_r[61:30];
        t_r  <= epg_pkg::Q30_ONE;
      end
      epg_pkg::OP_HQ:  p_r <= prod_r[62:30];
      epg_pkg::OP_HC:  t_r <= t_hc;
      epg_pkg::OP_SIN: begin
        s_r <= to_q17({1'b0, prod_r[60:30]});
        t_r <= epg_pkg::Q30_ONE;
      end
      epg_pkg::OP_COS: c_r <= to_q17({1'b0, t_r});
      epg_pkg::OP_V:   u_r <= prod_r[33:0];
      epg_pkg::OP_SQ1: v_r <= prod_r[33:0];
      epg_pkg::OP_SQ3: usq_r <= prod_r[61:0];
      epg_pkg::OP_DEN: den_r <= 35'(root) << sh;
      epg_pkg::OP_DX:  dx_r <= (nab ^ neg_c) ? -19'(mag) : 19'(mag);
      epg_pkg::OP_DY:  dy_r <= (nab ^ neg_s) ? -19'(mag) : 19'(mag);
      epg_pkg::OP_EMIT: begin
        if (stat.is_close) begin
          pt_x_r    <= first_x_r;
          pt_y_r    <= first_y_r;
          closing_r <= 1'b1;
        end else begin
          pt_x_r    <= px;
          pt_y_r    <= py;
          closing_r <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    stat.div_done  = div_done;
    stat.sqrt_done = sqrt_done;
    stat.is_close  = {1'b0, k_r} == SEG_K;
    stat.is_beyond = {1'b0, k_r} > SEG_K;
    stat.zero_axis = (ma == '0) || (mb == '0);
    stat.den_zero  = den_r == '0;
    stat.dup       = !stat.is_close && (k_r != '0) && have_first_r &&
                     (px == last_x_r) && (py == last_y_r);
  end

  assign point_x = pt_x_r;
  assign point_y = pt_y_r;
  assign closing = closing_r;

endmodule

// File: hw/rtl/epg_ctrl.sv
module epg_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  epg_pkg::dp_stat_t  stat,
  output epg_pkg::dp_cmd_t   cmd
);

  typedef enum logic [28:0] {
    ST_IDLE  = 29'h0000001,
    ST_CHECK = 29'h0000002,
    ST_ANGLE = 29'h0000004,
    ST_ADIV  = 29'h0000008,
    ST_AWAIT = 29'h0000010,
    ST_THETA = 29'h0000020,
    ST_X2    = 29'h0000040,
    ST_HP    = 29'h0000080,
    ST_HQ    = 29'h0000100,
    ST_HC    = 29'h0000200,
    ST_SMUL  = 29'h0000400,
    ST_SIN   = 29'h0000800,
    ST_COS   = 29'h0001000,
    ST_U     = 29'h0002000,
    ST_V     = 29'h0004000,
    ST_SQ1   = 29'h0008000,
    ST_SQ2   = 29'h0010000,
    ST_SQ3   = 29'h0020000,
    ST_ROOT  = 29'h0040000,
    ST_RWAIT = 29'h0080000,
    ST_DEN   = 29'h0100000,
    ST_DXS   = 29'h0200000,
    ST_DXW   = 29'h0400000,
    ST_DX    = 29'h0800000,
    ST_DYS   = 29'h1000000,
    ST_DYW   = 29'h2000000,
    ST_DY    = 29'h4000000,
    ST_EMIT  = 29'h8000000,
    ST_TSQ   = 29'h10000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] i_r, i_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       emit_ok;

  assign emit_ok  = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    cmd.op        = epg_pkg::OP_NONE;
    cmd.idx       = i_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = epg_pkg::OP_LOAD;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat.is_close)       state_nxt = ST_EMIT;
        else if (stat.is_beyond) state_nxt = ST_IDLE;
        else if (stat.zero_axis) state_nxt = ST_EMIT;
        else                     state_nxt = ST_ANGLE;
      end
      ST_ANGLE: begin
        cmd.op    = epg_pkg::OP_ANGLE;
        state_nxt = ST_ADIV;
      end
      ST_ADIV: begin
        cmd.op    = epg_pkg::OP_ADIV;
        state_nxt = ST_AWAIT;
      end
      ST_AWAIT: begin
        cmd.op    = epg_pkg::OP_AQ;
        state_nxt = ST_THETA;
      end
      ST_THETA: begin
        cmd.op    = epg_pkg::OP_THETA;
        state_nxt = ST_TSQ;
      end
      ST_TSQ: begin
        cmd.op    = epg_pkg::OP_TSQ;
        state_nxt = ST_X2;
      end
      ST_X2: begin
        cmd.op    = epg_pkg::OP_X2;
        i_nxt     = '0;
        state_nxt = ST_HP;
      end
      ST_HP: begin
        cmd.op    = epg_pkg::OP_HP;
        state_nxt = ST_HQ;
      end
      ST_HQ: begin
        cmd.op    = epg_pkg::OP_HQ;
        state_nxt = ST_HC;
      end
      ST_HC: begin
        cmd.op = epg_pkg::OP_HC;
        if (i_r == epg_pkg::SIN_LAST) begin
          state_nxt = ST_SMUL;
        end else if (i_r == epg_pkg::COS_LAST) begin
          state_nxt = ST_COS;
        end else begin
          i_nxt     = i_r + 4'd1;
          state_nxt = ST_HP;
        end
      end
      ST_SMUL: begin
        cmd.op    = epg_pkg::OP_SMUL;
        state_nxt = ST_SIN;
      end
      ST_SIN: begin
        cmd.op    = epg_pkg::OP_SIN;
        i_nxt     = i_r + 4'd1;
        state_nxt = ST_HP;
      end
      ST_COS: begin
        cmd.op    = epg_pkg::OP_COS;
        state_nxt = ST_U;
      end
      ST_U: begin
        cmd.op    = epg_pkg::OP_U;
        state_nxt = ST_V;
      end
      ST_V: begin
        cmd.op    = epg_pkg::OP_V;
        state_nxt = ST_SQ1;
      end
      ST_SQ1: begin
        cmd.op    = epg_pkg::OP_SQ1;
        state_nxt = ST_SQ2;
      end
      ST_SQ2: begin
        cmd.op    = epg_pkg::OP_SQ2;
        state_nxt = ST_SQ3;
      end
      ST_SQ3: begin
        cmd.op    = epg_pkg::OP_SQ3;
        state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.op    = epg_pkg::OP_ROOT;
        state_nxt = ST_RWAIT;
      end
      ST_RWAIT: begin
        if (stat.sqrt_done) state_nxt = ST_DEN;
      end
      ST_DEN: begin
        cmd.op    = epg_pkg::OP_DEN;
        state_nxt = ST_DXS;
      end
      ST_DXS: begin
        if (stat.den_zero) begin
          state_nxt = ST_EMIT;
        end else begin
          cmd.op    = epg_pkg::OP_DXS;
          state_nxt = ST_DXW;
        end
      end
      ST_DXW: begin
        if (stat.div_done) state_nxt = ST_DX;
      end
      ST_DX: begin
        cmd.op    = epg_pkg::OP_DX;
        state_nxt = ST_DYS;
      end
      ST_DYS: begin
        cmd.op    = epg_pkg::OP_DYS;
        state_nxt = ST_DYW;
      end
      ST_DYW: begin
        if (stat.div_done) state_nxt = ST_DY;
      end
      ST_DY: begin
        cmd.op    = epg_pkg::OP_DY;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.dup) begin
          state_nxt = ST_IDLE;
        end else if (emit_ok) begin
          cmd.op        = epg_pkg::OP_EMIT;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      i_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: hw/rtl/ellipse_polygon_point_generator.sv
// Ellipse polygon vertex generator. Program center and signed semi-axes on the
// cfg channel while idle, then send step indices 0..SEGMENTS-1 followed by
// SEGMENTS to close the polygon. Each step yields one vertex, rounded and
// saturated to 16 bits, unless it repeats the previous vertex; the closing
// step returns the first vertex with closing set. Steps above SEGMENTS give
// nothing. One step is handled at a time; a full vertex uses one shared 32-step
// restoring divider (used twice, once for each offset), a 32-step square root,
// and an 11-term sine/cosine Horner evaluation on a single shared multiplier;
// the angle uses a reciprocal multiply. The closing step and a degenerate
// (zero) axis skip the arithmetic; a step beyond range is dropped. A finished
// vertex sits in the output register while the next step is taken; a vertex
// that finds the previous one still unaccepted waits until it leaves.
module ellipse_polygon_point_generator #(
  parameter int SEGMENTS = 600
) (
  input  logic        clk,
  input  logic        rst_n,
  epg_cfg_if.sink     cfg_ch,
  epg_in_if.sink      in_ch,
  epg_out_if.source   out_ch
);

  epg_pkg::dp_cmd_t  cmd;
  epg_pkg::dp_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  epg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  epg_dp #(
    .SEGMENTS (SEGMENTS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_ch.valid),
    .cfg_idx  (cfg_ch.index),
    .cfg_data (cfg_ch.data),
    .in_k     (in_ch.step_index),
    .cmd      (cmd),
    .stat     (stat),
    .point_x  (out_ch.point_x),
    .point_y  (out_ch.point_y),
    .closing  (out_ch.closing)
  );

endmodule
